FILE: design/rcsa_pkg.sv
// package for the reference-counted slot allocator
// holds sizes, command and status codes and the controller state type
// no dependencies
package rcsa_pkg;

    localparam int SLOTS      = 256;
    localparam int COUNT_BITS = 8;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int PTR_W   = SLOT_W + 1;
    localparam int NUM_W   = $clog2(SLOTS + 1);
    localparam int CNT_W   = COUNT_BITS;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;

    localparam logic [PTR_W-1:0] NULL_PTR  = PTR_W'(SLOTS);
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RETAIN  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_FREE    = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_RANGE     = 3'd2,
        STAT_NOT_ALLOC = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

FILE: design/rcsa_if.sv
// channel interfaces of the slot allocator: command, result and configuration
// depends on rcsa_pkg
interface rcsa_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [rcsa_pkg::CMD_W-1:0]  cmd;
    logic [rcsa_pkg::SLOT_W-1:0] slot;

    modport source (output valid, output cmd, output slot, input ready);
    modport sink   (input valid, input cmd, input slot, output ready);
endinterface

interface rcsa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rcsa_pkg::STAT_W-1:0] status;
    logic [rcsa_pkg::SLOT_W-1:0] granted_slot;
    logic                        slot_freed;
    logic [rcsa_pkg::CNT_W-1:0]  ref_count;
    logic [rcsa_pkg::NUM_W-1:0]  in_use;

    modport source (output valid, output status, output granted_slot, output slot_freed,
                    output ref_count, output in_use, input ready);
    modport sink   (input valid, input status, input granted_slot, input slot_freed,
                    input ref_count, input in_use, output ready);
endinterface

interface rcsa_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rcsa_pkg::NUM_W-1:0] slot_count;

    modport source (output valid, output slot_count, input ready);
    modport sink   (input valid, input slot_count, output ready);
endinterface

FILE: design/rcsa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module rcsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/refcounted_slot_allocator.sv
// top level of the reference-counted slot allocator
// depends on rcsa_pkg, rcsa_if and rcsa_ram
//
// A command is accepted only in the idle state: the cycle in which it is accepted
// reads the next-pointer and count memories at the addressed slot (the free-list
// head for alloc), and the execute state, once the result register is free,
// modifies and writes both memories back and loads the result register, so no
// new command is accepted before the block returns to idle. A result that is not
// taken keeps the block in its execute state; the next command is accepted while a
// finished result still waits. Reset and a slot_count write clear the per-slot
// valid flags, and an untouched slot reads as its rebuilt state (count zero, link
// to the next higher slot), so there is no clearing pass. The configuration
// channel is always ready.
module refcounted_slot_allocator (
    input  logic        clk,
    input  logic        rst_n,
    rcsa_cfg_if.sink    cfg,
    rcsa_cmd_if.sink    req,
    rcsa_rsp_if.source  rsp
);

    localparam int SLOT_W = rcsa_pkg::SLOT_W;
    localparam int PTR_W  = rcsa_pkg::PTR_W;
    localparam int NUM_W  = rcsa_pkg::NUM_W;
    localparam int CNT_W  = rcsa_pkg::CNT_W;
    localparam int STAT_W = rcsa_pkg::STAT_W;

    rcsa_pkg::state_t      state_reg, state_next;
    rcsa_pkg::cmd_t        cmd_reg;
    logic [SLOT_W-1:0]     addr_reg;
    logic                  hit_reg;
    logic [PTR_W-1:0]      free_head_reg, free_head_next;
    logic [NUM_W-1:0]      in_use_reg, in_use_next;
    logic [NUM_W-1:0]      slot_count_reg, slot_count_next;
    logic [rcsa_pkg::SLOTS-1:0] vld_reg;

    logic                  rsp_valid_reg;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic [SLOT_W-1:0]     granted_reg, granted_next;
    logic                  freed_reg, freed_next;
    logic [CNT_W-1:0]      ref_count_reg, ref_count_next;

    logic                  accept, load, cfg_wr, rd_ready;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  nf_we, cnt_we, set_vld;
    logic [PTR_W-1:0]      nf_wdata, nf_rdata, nf_cur, succ, dflt_next;
    logic [CNT_W-1:0]      cnt_wdata, cnt_rdata, cnt_cur, cnt_dec;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;
    assign accept    = req.valid && rd_ready;
    assign load      = (state_reg == rcsa_pkg::ST_EXEC) && (!rsp_valid_reg || rsp.ready);
    assign req.ready = rd_ready;

    // alloc reads at the free-list head, all others at the given slot
    assign rd_addr = (rcsa_pkg::cmd_t'(req.cmd) == rcsa_pkg::CMD_ALLOC)
                   ? free_head_reg[SLOT_W-1:0] : req.slot;

    rcsa_ram #(.WIDTH(PTR_W), .DEPTH(rcsa_pkg::SLOTS)) u_next_ram (
        .clk   (clk),
        .we    (nf_we),
        .waddr (addr_reg),
        .wdata (nf_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (nf_rdata)
    );

    rcsa_ram #(.WIDTH(CNT_W), .DEPTH(rcsa_pkg::SLOTS)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (addr_reg),
        .wdata (cnt_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (cnt_rdata)
    );

    // a slot never written since the last rebuild reads as its rebuilt state
    assign succ      = {1'b0, addr_reg} + PTR_W'(1);
    assign dflt_next = (NUM_W'(succ) < slot_count_reg) ? succ : rcsa_pkg::NULL_PTR;
    assign nf_cur    = hit_reg ? nf_rdata : dflt_next;
    assign cnt_cur   = hit_reg ? cnt_rdata : '0;
    assign cnt_dec   = cnt_cur - CNT_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcsa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = rcsa_pkg::ST_EXEC;
                end
            end
            rcsa_pkg::ST_EXEC:
            begin
                if (load)
                begin
                    state_next = rcsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rcsa_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        case (state_reg)
            rcsa_pkg::ST_IDLE: rd_ready = 1'b1;
            rcsa_pkg::ST_EXEC: rd_ready = 1'b0;
            default:           rd_ready = 1'b0;
        endcase
    end

    // read-modify-write of one command
    always_comb
    begin
        status_next    = rcsa_pkg::STAT_OK;
        granted_next   = '0;
        freed_next     = 1'b0;
        ref_count_next = '0;
        free_head_next = free_head_reg;
        in_use_next    = in_use_reg;
        nf_we          = 1'b0;
        nf_wdata       = rcsa_pkg::NULL_PTR;
        cnt_we         = 1'b0;
        cnt_wdata      = '0;
        set_vld        = 1'b0;
        if (cmd_reg == rcsa_pkg::CMD_ALLOC)
        begin
            if (free_head_reg >= rcsa_pkg::NULL_PTR)
            begin
                status_next = rcsa_pkg::STAT_EMPTY;
            end
            else
            begin
                granted_next   = addr_reg;
                free_head_next = nf_cur;
                nf_we          = 1'b1;
                nf_wdata       = rcsa_pkg::NULL_PTR;
                cnt_we         = 1'b1;
                cnt_wdata      = CNT_W'(1);
                set_vld        = 1'b1;
                in_use_next    = in_use_reg + NUM_W'(1);
                ref_count_next = CNT_W'(1);
            end
        end
        else if (in_use_reg == '0 || NUM_W'(addr_reg) >= slot_count_reg)
        begin
            status_next = rcsa_pkg::STAT_RANGE;
        end
        else if (cnt_cur == '0)
        begin
            status_next = rcsa_pkg::STAT_NOT_ALLOC;
        end
        else
        begin
            case (cmd_reg)
                rcsa_pkg::CMD_RETAIN:
                begin
                    if (cnt_cur == rcsa_pkg::COUNT_MAX)
                    begin
                        status_next    = rcsa_pkg::STAT_FULL;
                        ref_count_next = cnt_cur;
                    end
                    else
                    begin
                        cnt_we         = 1'b1;
                        cnt_wdata      = cnt_cur + CNT_W'(1);
                        ref_count_next = cnt_cur + CNT_W'(1);
                    end
                end
                rcsa_pkg::CMD_RELEASE:
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_dec;
                    ref_count_next = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        nf_we          = 1'b1;
                        nf_wdata       = free_head_reg;
                        set_vld        = 1'b1;
                        free_head_next = {1'b0, addr_reg};
                        in_use_next    = in_use_reg - NUM_W'(1);
                        freed_next     = 1'b1;
                    end
                end
                rcsa_pkg::CMD_FREE:
                begin
                    cnt_we         = 1'b1;
                    cnt_wdata      = '0;
                    nf_we          = 1'b1;
                    nf_wdata       = free_head_reg;
                    set_vld        = 1'b1;
                    free_head_next = {1'b0, addr_reg};
                    in_use_next    = in_use_reg - NUM_W'(1);
                    freed_next     = 1'b1;
                end
                default:
                begin
                    status_next = rcsa_pkg::STAT_OK;
                end
            endcase
        end
        // writes only on the cycle the result is committed
        if (!load)
        begin
            nf_we   = 1'b0;
            cnt_we  = 1'b0;
            set_vld = 1'b0;
        end
    end

    // clamp the written slot count to 1..SLOTS
    always_comb
    begin
        if (cfg.slot_count == '0)
        begin
            slot_count_next = NUM_W'(1);
        end
        else if (cfg.slot_count > NUM_W'(rcsa_pkg::SLOTS))
        begin
            slot_count_next = NUM_W'(rcsa_pkg::SLOTS);
        end
        else
        begin
            slot_count_next = cfg.slot_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rcsa_pkg::ST_IDLE;
            free_head_reg  <= '0;
            in_use_reg     <= '0;
            slot_count_reg <= NUM_W'(rcsa_pkg::SLOTS);
            vld_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                slot_count_reg <= slot_count_next;
                free_head_reg  <= '0;
                in_use_reg     <= '0;
                vld_reg        <= '0;
            end
            else if (load)
            begin
                free_head_reg <= free_head_next;
                in_use_reg    <= in_use_next;
                if (set_vld)
                begin
                    vld_reg[addr_reg] <= 1'b1;
                end
            end
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= rcsa_pkg::cmd_t'(req.cmd);
            addr_reg <= rd_addr;
            hit_reg  <= vld_reg[rd_addr];
        end
        if (load)
        begin
            status_reg    <= status_next;
            granted_reg   <= granted_next;
            freed_reg     <= freed_next;
            ref_count_reg <= ref_count_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.granted_slot = granted_reg;
    assign rsp.slot_freed   = freed_reg;
    assign rsp.ref_count    = ref_count_reg;
    assign rsp.in_use       = in_use_reg;

endmodule

FILE: design/rcsa_checker.sv
// port-level checks for the slot allocator, bound to the top level
// depends on rcsa_pkg and refcounted_slot_allocator
module rcsa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [rcsa_pkg::STAT_W-1:0] status,
    input logic [rcsa_pkg::SLOT_W-1:0] granted_slot,
    input logic                        slot_freed,
    input logic [rcsa_pkg::CNT_W-1:0]  ref_count
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(ref_count))
        else $error("stalled result changed");

    // req_ready drops right after a command is accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command accepted in back-to-back cycles");

    // a slot goes back on the free list only with its count at zero
    a_freed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && slot_freed |-> status == rcsa_pkg::STAT_OK && ref_count == '0)
        else $error("freed slot with nonzero count");

    // a rejected or empty command grants nothing and frees nothing
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != rcsa_pkg::STAT_OK |-> granted_slot == '0 && !slot_freed)
        else $error("rejected command has side results");

endmodule

bind refcounted_slot_allocator rcsa_checker u_rcsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .granted_slot (rsp.granted_slot),
    .slot_freed   (rsp.slot_freed),
    .ref_count    (rsp.ref_count)
);

FILE: tb/tb_refcounted_slot_allocator.sv
// self-checking testbench for refcounted_slot_allocator: a table of directed commands,
// then random command streams under several idle and stall patterns, scored by a predictor
// depends on rcsa_pkg, rcsa_if and the allocator rtl
module tb_refcounted_slot_allocator;

    localparam int SLOTS  = rcsa_pkg::SLOTS;
    localparam int SLOT_W = rcsa_pkg::SLOT_W;
    localparam int PTR_W  = rcsa_pkg::PTR_W;
    localparam int NUM_W  = rcsa_pkg::NUM_W;
    localparam int CNT_W  = rcsa_pkg::CNT_W;

    localparam int HALF_PERIOD = 4;
    localparam int SETTLE      = 6;
    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 3000;

    typedef struct {
        rcsa_pkg::status_t  status;
        logic [SLOT_W-1:0]  granted;
        logic               freed;
        logic [CNT_W-1:0]   refs;
        logic [NUM_W-1:0]   used;
    } slot_result_t;

    typedef struct {
        bit           known;
        slot_result_t res;
    } typed_exp_t;

    typedef enum logic { ROW_CMD, ROW_CFG } row_kind_t;

    // arg is the slot index for a command row and the slot_count value for a config row
    typedef struct {
        row_kind_t          kind;
        rcsa_pkg::cmd_t     op;
        int                 arg;
        int                 reps;
        bit                 known;
        rcsa_pkg::status_t  st;
        int                 g;
        int                 f;
        int                 rc;
        int                 iu;
    } row_t;

    localparam int NROWS = 28;

    row_t plan [NROWS] = '{
        '{ROW_CMD, rcsa_pkg::CMD_RETAIN,  0,   1,   1'b1, rcsa_pkg::STAT_RANGE,     0, 0, 0,   0},
        '{ROW_CMD, rcsa_pkg::CMD_RELEASE, 255, 1,   1'b1, rcsa_pkg::STAT_RANGE,     0, 0, 0,   0},
        '{ROW_CMD, rcsa_pkg::CMD_FREE,    0,   1,   1'b1, rcsa_pkg::STAT_RANGE,     0, 0, 0,   0},
        '{ROW_CMD, rcsa_pkg::CMD_ALLOC,   0,   1,   1'b1, rcsa_pkg::STAT_OK,        0, 0, 1,   1},
        '{ROW_CMD, rcsa_pkg::CMD_ALLOC,   170, 1,   1'b1, rcsa_pkg::STAT_OK,        1, 0, 1,   2},
        '{ROW_CMD, rcsa_pkg::CMD_RETAIN,  5,   1,   1'b1, rcsa_pkg::STAT_NOT_ALLOC, 0, 0, 0,   2},
        '{ROW_CMD, rcsa_pkg::CMD_RETAIN,  0,   1,   1'b1, rcsa_pkg::STAT_OK,        0, 0, 2,   2},
        '{ROW_CMD, rcsa_pkg::CMD_RELEASE, 0,   1,   1'b1, rcsa_pkg::STAT_OK,        0, 0, 1,   2},
        '{ROW_CMD, rcsa_pkg::CMD_RELEASE, 0,   1,   1'b1, rcsa_pkg::STAT_OK,        0, 1, 0,   1},
        '{ROW_CMD, rcsa_pkg::CMD_ALLOC,   85,  1,   1'b1, rcsa_pkg::STAT_OK,        0, 0, 1,   2},
        '{ROW_CMD, rcsa_pkg::CMD_FREE,    1,   1,   1'b1, rcsa_pkg::STAT_OK,        0, 1, 0,   1},
        '{ROW_CMD, rcsa_pkg::CMD_RELEASE, 1,   1,   1'b1, rcsa_pkg::STAT_NOT_ALLOC, 0, 0, 0,   1},
        '{ROW_CMD, rcsa_pkg::CMD_FREE,    255, 1,   1'b1, rcsa_pkg::STAT_NOT_ALLOC, 0, 0, 0,   1},
        '{ROW_CMD, rcsa_pkg::CMD_RETAIN,  0,   254, 1'b0, rcsa_pkg::STAT_OK,        0, 0, 0,   0},
        '{ROW_CMD, rcsa_pkg::CMD_RETAIN,  0,   1,   1'b1, rcsa_pkg::STAT_FULL,      0, 0, 255, 1},
        '{ROW_CMD, rcsa_pkg::CMD_RELEASE, 0,   1,   1'b1, rcsa_pkg::STAT_OK,        0, 0, 254, 1},
        '{ROW_CMD, rcsa_pkg::CMD_FREE,    0,   1,   1'b1, rcsa_pkg::STAT_OK,        0, 1, 0,   0},
        '{ROW_CFG, rcsa_pkg::CMD_ALLOC,   1,   1,   1'b0, rcsa_pkg::STAT_OK,        0, 0, 0,   0},
        '{ROW_CMD, rcsa_pkg::CMD_ALLOC,   255, 1,   1'b1, rcsa_pkg::STAT_OK,        0, 0, 1,   1},
        '{ROW_CMD, rcsa_pkg::CMD_ALLOC,   0,   1,   1'b1, rcsa_pkg::STAT_EMPTY,     0, 0, 0,   1},
        '{ROW_CMD, rcsa_pkg::CMD_RETAIN,  1,   1,   1'b1, rcsa_pkg::STAT_RANGE,     0, 0, 0,   1},
        '{ROW_CMD, rcsa_pkg::CMD_RELEASE, 0,   1,   1'b1, rcsa_pkg::STAT_OK,        0, 1, 0,   0},
        '{ROW_CFG, rcsa_pkg::CMD_ALLOC,   0,   1,   1'b0, rcsa_pkg::STAT_OK,        0, 0, 0,   0},
        '{ROW_CMD, rcsa_pkg::CMD_ALLOC,   0,   1,   1'b1, rcsa_pkg::STAT_OK,        0, 0, 1,   1},
        '{ROW_CMD, rcsa_pkg::CMD_ALLOC,   0,   1,   1'b1, rcsa_pkg::STAT_EMPTY,     0, 0, 0,   1},
        '{ROW_CFG, rcsa_pkg::CMD_ALLOC,   511, 1,   1'b0, rcsa_pkg::STAT_OK,        0, 0, 0,   0},
        '{ROW_CMD, rcsa_pkg::CMD_ALLOC,   0,   1,   1'b1, rcsa_pkg::STAT_OK,        0, 0, 1,   1},
        '{ROW_CMD, rcsa_pkg::CMD_RETAIN,  255, 1,   1'b1, rcsa_pkg::STAT_NOT_ALLOC, 0, 0, 0,   1}
    };

    logic clk = 1'b0;
    logic rst_n;

    rcsa_cmd_if req ();
    rcsa_rsp_if rsp ();
    rcsa_cfg_if cfg ();

    refcounted_slot_allocator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    // predicted pool state
    logic [PTR_W-1:0] free_top;
    logic [PTR_W-1:0] link    [SLOTS];
    logic [CNT_W-1:0] ref_cnt [SLOTS];
    logic [NUM_W-1:0] slot_cnt;
    logic [NUM_W-1:0] live_cnt;

    slot_result_t result_q [$];
    typed_exp_t   typed_q  [$];

    int errors       = 0;
    int quiet        = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_off     = 1'b0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic void rebuild_pool(logic [NUM_W-1:0] v);
        slot_cnt = (v == 0) ? NUM_W'(1) : (v > SLOTS) ? NUM_W'(SLOTS) : v;
        for (int i = 0; i < SLOTS; i++)
        begin
            ref_cnt[i] = '0;
            link[i]    = (i + 1 < slot_cnt) ? PTR_W'(i + 1) : rcsa_pkg::NULL_PTR;
        end
        free_top = '0;
        live_cnt = '0;
    endfunction

    function automatic slot_result_t predict_cmd(rcsa_pkg::cmd_t op, logic [SLOT_W-1:0] s);
        slot_result_t r;
        r = '{status: rcsa_pkg::STAT_OK, granted: '0, freed: 1'b0, refs: '0, used: '0};
        if (op == rcsa_pkg::CMD_ALLOC)
        begin
            if (free_top == rcsa_pkg::NULL_PTR)
                r.status = rcsa_pkg::STAT_EMPTY;
            else
            begin
                r.granted = free_top[SLOT_W-1:0];
                free_top = link[r.granted];
                link[r.granted] = rcsa_pkg::NULL_PTR;
                ref_cnt[r.granted] = CNT_W'(1);
                live_cnt++;
                r.refs = CNT_W'(1);
            end
        end
        else if (live_cnt == 0 || {1'b0, s} >= slot_cnt)
            r.status = rcsa_pkg::STAT_RANGE;
        else if (ref_cnt[s] == 0)
            r.status = rcsa_pkg::STAT_NOT_ALLOC;
        else if (op == rcsa_pkg::CMD_RETAIN)
        begin
            if (ref_cnt[s] == rcsa_pkg::COUNT_MAX)
                r.status = rcsa_pkg::STAT_FULL;
            else
                ref_cnt[s]++;
            r.refs = ref_cnt[s];
        end
        else
        begin
            // release only returns the slot once its count drops to zero; free always does
            if (op == rcsa_pkg::CMD_RELEASE)
                ref_cnt[s]--;
            else
                ref_cnt[s] = '0;
            if (ref_cnt[s] == 0)
            begin
                link[s] = free_top;
                free_top = {1'b0, s};
                live_cnt--;
                r.freed = 1'b1;
            end
            r.refs = ref_cnt[s];
        end
        r.used = live_cnt;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // scoreboard: results are checked before this edge's command is predicted
    always @(posedge clk)
    begin
        slot_result_t want;
        typed_exp_t   t;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result transaction with no expectation pending");
                    errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("status", 16'(want.status), 16'(rsp.status));
                    check_field("granted_slot", 16'(want.granted), 16'(rsp.granted_slot));
                    check_field("slot_freed", 16'(want.freed), 16'(rsp.slot_freed));
                    check_field("ref_count", 16'(want.refs), 16'(rsp.ref_count));
                    check_field("in_use", 16'(want.used), 16'(rsp.in_use));
                end
            end
            if (cfg.valid && cfg.ready)
                rebuild_pool(cfg.slot_count);
            if (req.valid && req.ready)
            begin
                t = typed_q.pop_front();
                want = predict_cmd(rcsa_pkg::cmd_t'(req.cmd), req.slot);
                result_q.push_back(t.known ? t.res : want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
            || (cfg.valid && cfg.ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            rsp.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    task automatic offer_cmd(rcsa_pkg::cmd_t op, logic [SLOT_W-1:0] s, bit known,
                             slot_result_t res);
        typed_q.push_back('{known: known, res: res});
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd   <= op;
        req.slot  <= s;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        while (result_q.size() != 0 || typed_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_slot_count(logic [NUM_W-1:0] v);
        drain_results();
        repeat (SETTLE) @(posedge clk);
        cfg.valid      <= 1'b1;
        cfg.slot_count <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // mostly commands on live slots, the rest on any slot index
    task automatic offer_random();
        slot_result_t      none;
        rcsa_pkg::cmd_t    op;
        logic [SLOT_W-1:0] s;
        int                pick;
        int                base;
        int                idx;
        none = '{status: rcsa_pkg::STAT_OK, granted: '0, freed: 1'b0, refs: '0, used: '0};
        pick = $urandom_range(0, 99);
        op = (pick < 35) ? rcsa_pkg::CMD_ALLOC : (pick < 60) ? rcsa_pkg::CMD_RETAIN :
             (pick < 85) ? rcsa_pkg::CMD_RELEASE : rcsa_pkg::CMD_FREE;
        s = SLOT_W'($urandom);
        if ($urandom_range(0, 99) < 75)
        begin
            base = $urandom_range(0, SLOTS - 1);
            for (int k = 0; k < SLOTS; k++)
            begin
                idx = (base + k) % SLOTS;
                if (idx < slot_cnt && ref_cnt[idx] != 0)
                begin
                    s = SLOT_W'(idx);
                    break;
                end
            end
        end
        offer_cmd(op, s, 1'b0, none);
    endtask

    initial
    begin
        slot_result_t typed;
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.cmd        <= rcsa_pkg::CMD_ALLOC;
        req.slot       <= '0;
        cfg.valid      <= 1'b0;
        cfg.slot_count <= '0;
        rebuild_pool(NUM_W'(SLOTS));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_slot_count(NUM_W'(plan[i].arg));
            else
            begin
                typed.status  = plan[i].st;
                typed.granted = SLOT_W'(plan[i].g);
                typed.freed   = plan[i].f[0];
                typed.refs    = CNT_W'(plan[i].rc);
                typed.used    = NUM_W'(plan[i].iu);
                repeat (plan[i].reps)
                    offer_cmd(plan[i].op, SLOT_W'(plan[i].arg), plan[i].known, typed);
            end
        end

        // no idling; the result side holds off while commands keep coming
        write_slot_count(NUM_W'(8));
        hold_off = 1'b1;
        repeat (40) offer_random();
        drain_results();
        repeat (20) offer_random();

        write_slot_count(NUM_W'(SLOTS));
        tx_idle_pct = 88;
        repeat (40) offer_random();

        write_slot_count(NUM_W'(3));
        tx_idle_pct  = 0;
        rx_stall_pct = 88;
        repeat (40) offer_random();

        write_slot_count(NUM_W'(16));
        tx_idle_pct  = 37;
        rx_stall_pct = 37;
        repeat (20) offer_random();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        repeat (15) offer_random();

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: refcounted_slot_allocator.f
design/rcsa_pkg.sv
design/rcsa_if.sv
design/rcsa_ram.sv
design/refcounted_slot_allocator.sv
design/rcsa_checker.sv
tb/tb_refcounted_slot_allocator.sv
